/* design/otp_dp_pkg.sv */
package otp_dp_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_SYMBOLS = 16;
  localparam int DEF_MAX_LENGTH  = 32;

  // fixed field widths
  localparam int SYM_W     = 4;
  localparam int CFG_W     = 5;
  localparam int LEN_OUT_W = 6;

  localparam logic [CFG_W-1:0] NS_RESET = 5'd16;

  // request codes
  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_SEQ   = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic tbl_wr;    // write operation table entry from input item
    logic seq_wr;    // append sequence symbol from input item
    logic tgt_ld;    // latch target symbol
    logic seq_rd;    // read sequence store
    logic leaf_wr;   // write leaf set of the symbol just read
    logic split_rd;  // read left and right sets of one split
    logic pair_en;   // one operand pair through the table
    logic acc_clr;   // clear the interval accumulator
    logic set_wr;    // write the accumulator to the interval store
    logic fin_rd;    // read the set of the whole sequence
  } cmd_t;

endpackage

/* design/otp_dp_path.sv */
module otp_dp_path #(
  parameter int MAX_SYMBOLS = otp_dp_pkg::DEF_MAX_SYMBOLS,
  parameter int MAX_LENGTH  = otp_dp_pkg::DEF_MAX_LENGTH,
  localparam int SW  = $clog2(MAX_SYMBOLS),
  localparam int LW  = $clog2(MAX_LENGTH),
  localparam int TAW = $clog2(MAX_SYMBOLS * MAX_SYMBOLS),
  localparam int RAW = $clog2(MAX_LENGTH * MAX_LENGTH)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [otp_dp_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [otp_dp_pkg::SYM_W-1:0]    in_table_left,
  input  logic [otp_dp_pkg::SYM_W-1:0]    in_table_right,
  input  logic [otp_dp_pkg::SYM_W-1:0]    in_table_value,
  input  logic [otp_dp_pkg::SYM_W-1:0]    in_seq_symbol,
  input  logic [otp_dp_pkg::SYM_W-1:0]    in_target_symbol,
  input  otp_dp_pkg::cmd_t                cmd,
  input  logic [LW-1:0]                   seq_addr,
  input  logic [LW-1:0]                   ra_row,
  input  logic [LW-1:0]                   ra_col,
  input  logic [LW-1:0]                   rb_row,
  input  logic [LW-1:0]                   rb_col,
  input  logic [LW-1:0]                   w_row,
  input  logic [LW-1:0]                   w_col,
  input  logic [SW-1:0]                   op_a,
  input  logic [SW-1:0]                   op_b,
  output logic                            found
);

  localparam int NSW = $clog2(MAX_SYMBOLS + 1);

  logic [otp_dp_pkg::CFG_W-1:0] cfg_r;
  logic [NSW-1:0]               ns;
  logic [otp_dp_pkg::SYM_W-1:0] op_table [MAX_SYMBOLS*MAX_SYMBOLS];
  logic [otp_dp_pkg::SYM_W-1:0] seq_store [MAX_LENGTH];
  logic [MAX_SYMBOLS-1:0]       reach_sets [MAX_LENGTH*MAX_LENGTH];
  logic [otp_dp_pkg::SYM_W-1:0] seq_q_r;
  logic [otp_dp_pkg::SYM_W-1:0] tbl_q_r;
  logic [otp_dp_pkg::SYM_W-1:0] tgt_r;
  logic [MAX_SYMBOLS-1:0]       set_a_r;
  logic [MAX_SYMBOLS-1:0]       set_b_r;
  logic [MAX_SYMBOLS-1:0]       acc_r;
  logic [MAX_SYMBOLS-1:0]       acc_nxt;
  logic [MAX_SYMBOLS-1:0]       leaf;
  logic [MAX_SYMBOLS-1:0]       prod;
  logic [MAX_SYMBOLS-1:0]       wdata;
  logic [MAX_SYMBOLS-1:0]       tgt_sh;
  logic                         hit_r;
  logic                         tbl_ok;
  logic [TAW-1:0]               tbl_waddr;
  logic [TAW-1:0]               tbl_raddr;
  logic [RAW-1:0]               addr_a;
  logic [RAW-1:0]               addr_b;
  logic [RAW-1:0]               addr_w;

  // configuration register and effective symbol count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= otp_dp_pkg::NS_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign ns = (32'(cfg_r) > MAX_SYMBOLS) ? NSW'(MAX_SYMBOLS) : NSW'(cfg_r);

  // table addressing
  assign tbl_ok = (32'(in_table_left) < MAX_SYMBOLS) && (32'(in_table_right) < MAX_SYMBOLS);
  assign tbl_waddr = TAW'(in_table_left) * TAW'(MAX_SYMBOLS) + TAW'(in_table_right);
  assign tbl_raddr = TAW'(op_a) * TAW'(MAX_SYMBOLS) + TAW'(op_b);

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && tbl_ok) begin
      op_table[tbl_waddr] <= in_table_value;
    end
    tbl_q_r <= op_table[tbl_raddr];
  end

  // sequence store
  always_ff @(posedge clk) begin
    if (cmd.seq_wr) begin
      seq_store[seq_addr] <= in_seq_symbol;
    end
    if (cmd.seq_rd) begin
      seq_q_r <= seq_store[seq_addr];
    end
    if (cmd.tgt_ld) begin
      tgt_r <= in_target_symbol;
    end
  end

  // leaf set and table product decode
  always_comb begin
    for (int x = 0; x < MAX_SYMBOLS; x++) begin
      leaf[x] = (32'(seq_q_r) == x) && (32'(seq_q_r) < 32'(ns));
      prod[x] = (32'(tbl_q_r) == x) && (32'(tbl_q_r) < 32'(ns));
    end
  end

  // interval store, one write and two registered reads
  assign addr_a = RAW'(ra_row) * RAW'(MAX_LENGTH) + RAW'(ra_col);
  assign addr_b = RAW'(rb_row) * RAW'(MAX_LENGTH) + RAW'(rb_col);
  assign addr_w = RAW'(w_row) * RAW'(MAX_LENGTH) + RAW'(w_col);
  assign wdata  = cmd.leaf_wr ? leaf : acc_r;

  always_ff @(posedge clk) begin
    if (cmd.leaf_wr || cmd.set_wr) begin
      reach_sets[addr_w] <= wdata;
    end
    if (cmd.split_rd || cmd.fin_rd) begin
      set_a_r <= reach_sets[addr_a];
    end
    if (cmd.split_rd) begin
      set_b_r <= reach_sets[addr_b];
    end
  end

  // pair pipeline: table read then accumulate
  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (hit_r) begin
      acc_nxt = acc_r | prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= cmd.pair_en && set_a_r[op_a] && set_b_r[op_b];
    end
    acc_r <= acc_nxt;
  end

  // target test on the whole sequence set
  assign tgt_sh = set_a_r >> tgt_r;
  assign found  = (32'(tgt_r) < 32'(ns)) && tgt_sh[0];

endmodule

/* design/otp_dp_ctrl.sv */
module otp_dp_ctrl #(
  parameter int MAX_SYMBOLS = otp_dp_pkg::DEF_MAX_SYMBOLS,
  parameter int MAX_LENGTH  = otp_dp_pkg::DEF_MAX_LENGTH,
  localparam int SW = $clog2(MAX_SYMBOLS),
  localparam int LW = $clog2(MAX_LENGTH),
  localparam int CW = $clog2(MAX_LENGTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_req_type,
  input  logic                              in_seq_last,
  output logic                              busy,
  output logic                              out_valid,
  output logic [otp_dp_pkg::LEN_OUT_W-1:0]  out_seq_length,
  output otp_dp_pkg::cmd_t                  cmd,
  output logic [LW-1:0]                     seq_addr,
  output logic [LW-1:0]                     ra_row,
  output logic [LW-1:0]                     ra_col,
  output logic [LW-1:0]                     rb_row,
  output logic [LW-1:0]                     rb_col,
  output logic [LW-1:0]                     w_row,
  output logic [LW-1:0]                     w_col,
  output logic [SW-1:0]                     op_a,
  output logic [SW-1:0]                     op_b
);

  typedef enum logic [3:0] {
    IDLE, LEAF_RD, LEAF_WR, SPLIT_RD, PAIR, DRAIN, SET_WR, FIN_RD, FIN_OUT
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   len_r;
  logic [CW-1:0]   cnt_inc;
  logic [LW-1:0]   len_m1;
  logic [LW-1:0]   i_r;
  logic [LW-1:0]   j_r;
  logic [LW-1:0]   k_r;
  logic [2*SW-1:0] p_r;
  logic            acc_seq;

  assign busy      = (state_r != IDLE);
  assign acc_seq   = start && !busy && (in_req_type == otp_dp_pkg::REQ_SEQ);
  assign cnt_inc   = (32'(cnt_r) < MAX_LENGTH) ? cnt_r + CW'(1) : cnt_r;
  assign len_m1    = LW'(len_r - CW'(1));
  assign out_valid = (state_r == FIN_OUT);
  assign out_seq_length = otp_dp_pkg::LEN_OUT_W'(len_r);
  assign op_a      = p_r[2*SW-1:SW];
  assign op_b      = p_r[SW-1:0];

  // commands and addresses
  always_comb begin
    cmd          = '0;
    cmd.tbl_wr   = start && !busy && (in_req_type == otp_dp_pkg::REQ_TABLE);
    cmd.seq_wr   = acc_seq && (32'(cnt_r) < MAX_LENGTH);
    cmd.tgt_ld   = acc_seq && in_seq_last;
    cmd.seq_rd   = (state_r == LEAF_RD);
    cmd.leaf_wr  = (state_r == LEAF_WR);
    cmd.split_rd = (state_r == SPLIT_RD);
    cmd.acc_clr  = (state_r == SPLIT_RD) && (k_r == i_r);
    cmd.pair_en  = (state_r == PAIR);
    cmd.set_wr   = (state_r == SET_WR);
    cmd.fin_rd   = (state_r == FIN_RD);
    seq_addr     = (state_r == IDLE) ? LW'(cnt_r) : i_r;
    ra_row       = (state_r == FIN_RD) ? '0 : i_r;
    ra_col       = (state_r == FIN_RD) ? len_m1 : k_r;
    rb_row       = k_r + LW'(1);
    rb_col       = j_r;
    w_row        = i_r;
    w_col        = (state_r == LEAF_WR) ? i_r : j_r;
  end

  // sequencer over leaves, intervals, splits and operand pairs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      cnt_r   <= '0;
      len_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      p_r     <= '0;
    end else begin
      case (state_r)
        IDLE: begin
          if (acc_seq) begin
            if (in_seq_last) begin
              len_r   <= cnt_inc;
              cnt_r   <= '0;
              i_r     <= '0;
              state_r <= LEAF_RD;
            end else begin
              cnt_r <= cnt_inc;
            end
          end
        end
        LEAF_RD: begin
          state_r <= LEAF_WR;
        end
        LEAF_WR: begin
          if (i_r == len_m1) begin
            i_r <= '0;
            j_r <= LW'(1);
            k_r <= '0;
            state_r <= (len_m1 == '0) ? FIN_RD : SPLIT_RD;
          end else begin
            i_r     <= i_r + LW'(1);
            state_r <= LEAF_RD;
          end
        end
        SPLIT_RD: begin
          p_r     <= '0;
          state_r <= PAIR;
        end
        PAIR: begin
          p_r <= p_r + (2*SW)'(1);
          if (p_r == '1) begin
            state_r <= DRAIN;
          end
        end
        DRAIN: begin
          if (k_r + LW'(1) != j_r) begin
            k_r     <= k_r + LW'(1);
            state_r <= SPLIT_RD;
          end else begin
            state_r <= SET_WR;
          end
        end
        SET_WR: begin
          if (j_r == len_m1) begin
            if (i_r == '0) begin
              state_r <= FIN_RD;
            end else begin
              i_r     <= '0;
              k_r     <= '0;
              j_r     <= j_r - i_r + LW'(1);
              state_r <= SPLIT_RD;
            end
          end else begin
            i_r     <= i_r + LW'(1);
            k_r     <= i_r + LW'(1);
            j_r     <= j_r + LW'(1);
            state_r <= SPLIT_RD;
          end
        end
        FIN_RD: begin
          state_r <= FIN_OUT;
        end
        FIN_OUT: begin
          state_r <= IDLE;
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

endmodule

/* design/operator_table_parenthesization_dp.sv */
// table writes and non-final appends are accepted back to back while idle
// final append: read and write each leaf; per interval split read both sets, one table
// read per operand pair, drain; L(L-1)(L+1)/6 splits; set write per interval, final read
// result strobe lasts one cycle, receiver cannot stall; busy high during evaluation
// synchronous active-low reset clears control state and sets num_symbols to 16
module operator_table_parenthesization_dp #(
  parameter int MAX_SYMBOLS = otp_dp_pkg::DEF_MAX_SYMBOLS,
  parameter int MAX_LENGTH  = otp_dp_pkg::DEF_MAX_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [otp_dp_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_req_type,
  input  logic [otp_dp_pkg::SYM_W-1:0]      in_table_left,
  input  logic [otp_dp_pkg::SYM_W-1:0]      in_table_right,
  input  logic [otp_dp_pkg::SYM_W-1:0]      in_table_value,
  input  logic [otp_dp_pkg::SYM_W-1:0]      in_seq_symbol,
  input  logic [otp_dp_pkg::SYM_W-1:0]      in_target_symbol,
  input  logic                              in_seq_last,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [otp_dp_pkg::LEN_OUT_W-1:0]  out_seq_length
);

  localparam int SW = $clog2(MAX_SYMBOLS);
  localparam int LW = $clog2(MAX_LENGTH);

  otp_dp_pkg::cmd_t cmd;
  logic [LW-1:0]    seq_addr;
  logic [LW-1:0]    ra_row;
  logic [LW-1:0]    ra_col;
  logic [LW-1:0]    rb_row;
  logic [LW-1:0]    rb_col;
  logic [LW-1:0]    w_row;
  logic [LW-1:0]    w_col;
  logic [SW-1:0]    op_a;
  logic [SW-1:0]    op_b;

  // controller
  otp_dp_ctrl #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_req_type   (in_req_type),
    .in_seq_last   (in_seq_last),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_seq_length(out_seq_length),
    .cmd           (cmd),
    .seq_addr      (seq_addr),
    .ra_row        (ra_row),
    .ra_col        (ra_col),
    .rb_row        (rb_row),
    .rb_col        (rb_col),
    .w_row         (w_row),
    .w_col         (w_col),
    .op_a          (op_a),
    .op_b          (op_b)
  );

  // datapath
  otp_dp_path #(
    .MAX_SYMBOLS(MAX_SYMBOLS),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_path (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_table_left   (in_table_left),
    .in_table_right  (in_table_right),
    .in_table_value  (in_table_value),
    .in_seq_symbol   (in_seq_symbol),
    .in_target_symbol(in_target_symbol),
    .cmd             (cmd),
    .seq_addr        (seq_addr),
    .ra_row          (ra_row),
    .ra_col          (ra_col),
    .rb_row          (rb_row),
    .rb_col          (rb_col),
    .w_row           (w_row),
    .w_col           (w_col),
    .op_a            (op_a),
    .op_b            (op_b),
    .found           (out_found)
  );

endmodule
